// ----- hdl/ditp_pkg.sv -----
// Shared types and constants for the delimited integer token parser.
// No dependencies; imported by every other file in hdl.
package ditp_pkg;

    // Conversion phases of one token.
    localparam logic [1:0] PHASE_SPACE  = 2'd0;
    localparam logic [1:0] PHASE_DIGITS = 2'd1;
    localparam logic [1:0] PHASE_STOP   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_DELIM_MASK_0 = 2'd0;
    localparam logic [1:0] REG_DELIM_MASK_1 = 2'd1;
    localparam logic [1:0] REG_DELIM_MASK_2 = 2'd2;
    localparam logic [1:0] REG_DELIM_MASK_3 = 2'd3;

    localparam int unsigned MASK_W = 64;
    localparam int unsigned MAG_W  = 32;

    // Magnitude ceiling, and the largest positive result.
    localparam logic [MAG_W-1:0] MAG_CAP = 32'h8000_0000;
    localparam logic [MAG_W-1:0] POS_MAX = 32'h7FFF_FFFF;

    // Running state of the open token.
    typedef struct packed {
        logic             in_token;
        logic [1:0]       phase;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } token_state_t;

    // One result item.
    typedef struct packed {
        logic [MAG_W-1:0] value;
        logic             valid;
        logic             done;
    } token_result_t;

    localparam token_state_t TOKEN_CLEAR = '{
        in_token:  1'b0,
        phase:     PHASE_SPACE,
        negative:  1'b0,
        magnitude: '0
    };

endpackage

// ----- hdl/ditp_step.sv -----
// One byte of token parsing: next token state and the result it may cause.
// Depends on ditp_pkg.
module ditp_step
    import ditp_pkg::*;
(
    input  token_state_t  state_cur,
    input  logic [7:0]    char_byte,
    input  logic          end_of_string,
    input  logic          is_delim,
    output token_state_t  state_new,
    output logic          emit,
    output token_result_t result
);

    logic             is_space;
    logic             is_sign;
    logic             is_digit;
    logic [3:0]       digit_val;
    logic [MAG_W+3:0] mag_times_ten;
    logic [MAG_W+3:0] mag_sum;
    token_state_t     fed;

    // Character classes.
    assign is_space  = (char_byte == 8'd32) || (char_byte >= 8'd9 && char_byte <= 8'd13);
    assign is_sign   = (char_byte == 8'd43) || (char_byte == 8'd45);
    assign is_digit  = (char_byte >= 8'd48) && (char_byte <= 8'd57);
    assign digit_val = 4'(char_byte - 8'd48);

    // Times ten as two shifted adds, then the digit, then the ceiling.
    assign mag_times_ten = {1'b0, state_cur.magnitude, 3'b000}
                         + {3'b000, state_cur.magnitude, 1'b0};
    assign mag_sum       = mag_times_ten + {{MAG_W{1'b0}}, digit_val};

    // Fold a non-delimiter byte into the token state.
    always_comb begin
        fed = state_cur;
        if (!is_delim) begin
            fed.in_token = 1'b1;
            if (state_cur.phase == PHASE_SPACE) begin
                if (is_space) begin
                    fed.phase = PHASE_SPACE;
                end else if (is_sign) begin
                    fed.negative = (char_byte == 8'd45);
                    fed.phase    = PHASE_DIGITS;
                end else if (is_digit) begin
                    fed.phase     = PHASE_DIGITS;
                    fed.magnitude = (mag_sum > {4'b0000, MAG_CAP}) ? MAG_CAP
                                                                   : mag_sum[MAG_W-1:0];
                end else begin
                    fed.phase = PHASE_STOP;
                end
            end else if (state_cur.phase == PHASE_DIGITS) begin
                if (is_digit) begin
                    fed.magnitude = (mag_sum > {4'b0000, MAG_CAP}) ? MAG_CAP
                                                                   : mag_sum[MAG_W-1:0];
                end else begin
                    fed.phase = PHASE_STOP;
                end
            end
        end
    end

    // A result comes at the string end, or at a delimiter closing an open token.
    assign emit = end_of_string || (is_delim && state_cur.in_token);

    always_comb begin
        result.valid = fed.in_token;
        result.done  = end_of_string;
        if (!fed.in_token) begin
            result.value = '0;
        end else if (fed.negative) begin
            result.value = '0 - fed.magnitude;
        end else if (fed.magnitude >= MAG_CAP) begin
            result.value = POS_MAX;
        end else begin
            result.value = fed.magnitude;
        end
    end

    // Every result closes the token.
    assign state_new = emit ? TOKEN_CLEAR : fed;

endmodule

// ----- hdl/ditp_out_buf.sv -----
// Two-entry output buffer that lets the parser run while a result waits.
// Depends on ditp_pkg.
module ditp_out_buf
    import ditp_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  token_result_t push_data,
    output logic          full,
    output logic          out_valid,
    input  logic          out_ready,
    output token_result_t out_data
);

    token_result_t entry_reg [2];
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          pop;
    logic          wr_slot;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = entry_reg[0];
    assign full      = (count_reg == 2'd2);

    // The new item lands behind whatever stays after this cycle's pop.
    assign wr_slot    = (count_reg == 2'd2) || (count_reg == 2'd1 && !pop);
    assign count_next = count_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    // Payload shifts forward on a pop; a new item fills the slot behind it.
    always_ff @(posedge aclk) begin
        if (push && !wr_slot) begin
            entry_reg[0] <= push_data;
        end else if (pop) begin
            entry_reg[0] <= entry_reg[1];
        end
        if (push && wr_slot) begin
            entry_reg[1] <= push_data;
        end
    end

    // The count never passes two.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("output buffer count out of range");

    // No item arrives while both entries are held.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("output buffer overflow");

    // A held head item stays until it is taken.
    a_head_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("output head item changed while stalled");

endmodule

// ----- hdl/delimited_integer_token_parser.sv -----
// A result item is written into the output buffer when the byte that closes its token is accepted.
// Throughput: one byte per cycle while input ready is high; the token state update is a loop through tok_reg.
// A two-entry output buffer keeps bytes flowing while one result waits;
// input ready drops only when both entries are held.
// Reset (synchronous, active low) clears the delimiter set, the open token
// and the output buffer.
module delimited_integer_token_parser
    import ditp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Configuration write port
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_addr,
    input  logic [MASK_W-1:0] cfg_wdata,
    // Input bytes
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_char_byte,
    input  logic              s_end_of_string,
    // Results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_token_value,
    output logic              m_token_valid,
    output logic              m_string_done
);

    logic [MASK_W-1:0] mask_reg [4];
    token_state_t      tok_reg;
    token_state_t      tok_next;
    logic              accept;
    logic              is_delim;
    logic              emit;
    logic              buf_full;
    token_result_t     step_result;
    token_result_t     out_data;

    assign s_ready = !buf_full;
    assign accept  = s_valid && s_ready;

    // Delimiter set registers; the NUL byte never counts as a delimiter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                mask_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            mask_reg[cfg_addr] <= cfg_wdata;
        end
    end

    assign is_delim = (s_char_byte != 8'd0) && mask_reg[s_char_byte[7:6]][s_char_byte[5:0]];

    ditp_step u_step (
        .state_cur     (tok_reg),
        .char_byte     (s_char_byte),
        .end_of_string (s_end_of_string),
        .is_delim      (is_delim),
        .state_new     (tok_next),
        .emit          (emit),
        .result        (step_result)
    );

    // Token state advances on each accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= TOKEN_CLEAR;
        end else if (accept) begin
            tok_reg <= tok_next;
        end
    end

    ditp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept && emit),
        .push_data (step_result),
        .full      (buf_full),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_token_value = out_data.value;
    assign m_token_valid = out_data.valid;
    assign m_string_done = out_data.done;

    // The magnitude never exceeds the ceiling.
    a_mag_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_reg.magnitude <= MAG_CAP)
        else $error("token magnitude above ceiling");

    // The last byte of a string always leaves the token closed.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_end_of_string) |=> (!tok_reg.in_token && tok_reg.phase == PHASE_SPACE))
        else $error("token not closed after last byte");

    // An ordinary byte inside a string opens or continues a token.
    a_byte_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_end_of_string && !is_delim) |=> tok_reg.in_token)
        else $error("token not open after an ordinary byte");

endmodule
